### rtl/adf_pkg.sv
package adf_pkg;

   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;
   localparam logic [7:0] CHAR_POINT = 8'h2e;
   localparam logic [7:0] CHAR_MINUS = 8'h2d;

   localparam int unsigned VALUE_BITS  = 64;
   localparam int unsigned COUNT_BITS  = 4;
   localparam int unsigned WEIGHT_SLOTS = 16;

   typedef struct packed {
      logic [7:0] character;
      logic       last;
   } adf_req_type;

   typedef struct packed {
      logic signed [VALUE_BITS-1:0] value;
      logic                         overflow;
   } adf_rsp_type;

   // ten to the power k, by repeated multiplication
   function automatic logic [63:0] pow10(input int unsigned k);
      logic [63:0] p;
      p = 64'd1;
      for (int unsigned i = 0; i < k; i++) begin
         p = p * 64'd10;
      end
      return p;
   endfunction

endpackage

### rtl/ascii_decimal_to_fixed_unit.sv
// Parses a signed decimal number sent as one ASCII character per transfer, the final
// character flagged by last, and returns one signed fixed-point result (INT_BITS integer
// bits, FRAC_BITS fraction bits, Q32.32 by default) for each number. A leading '-' makes
// the number negative, the first '.' starts the fraction, and any other character is
// ignored. Fraction digits past FRAC_DIGITS are dropped. An integer part too large for
// INT_BITS saturates and sets overflow, as does a value beyond the signed output range.
// A new character is taken every cycle while req_stall is low; a result passes through
// the input register, the finished number snapshot and the result register (accumulator
// update and output formatting lie between them), and the accumulators return to their
// start state right after that character, so numbers may follow each other without gaps.
module ascii_decimal_to_fixed_unit #(
   parameter int unsigned INT_BITS    = 32,
   parameter int unsigned FRAC_BITS   = 32,
   parameter int unsigned FRAC_DIGITS = 9
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  adf_pkg::adf_req_type req_payload,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output adf_pkg::adf_rsp_type rsp_payload
);
   import adf_pkg::*;

   localparam int unsigned MAG_BITS = INT_BITS + FRAC_BITS;
   localparam int unsigned TOTAL_BITS = (MAG_BITS > VALUE_BITS) ? VALUE_BITS : MAG_BITS;
   localparam logic [VALUE_BITS-1:0] LIM_NEG = 64'd1 << (TOTAL_BITS - 1);
   localparam logic [VALUE_BITS-1:0] LIM_POS = LIM_NEG - 64'd1;

   typedef struct packed {
      logic [INT_BITS-1:0]  whole;
      logic [FRAC_BITS-1:0] frac;
      logic                 negative;
      logic                 saturated;
   } adf_final_type;

   // fraction digit weights, round half up of 2^FRAC_BITS / 10^k
   logic [FRAC_BITS-1:0] weight_table [WEIGHT_SLOTS];

   for (genvar k = 0; k < WEIGHT_SLOTS; k++) begin : g_weight
      if (k >= 1 && k <= FRAC_DIGITS) begin : g_on
         localparam logic [63:0] POW = pow10(k);
         localparam logic [63:0] WEIGHT = ((64'd1 << FRAC_BITS) + POW / 2) / POW;
         assign weight_table[k] = WEIGHT[FRAC_BITS-1:0];
      end else begin : g_off
         assign weight_table[k] = '0;
      end
   end

   // input register
   logic        in_valid_ff, in_valid_in;
   adf_req_type in_ff;

   // accumulator state
   logic [INT_BITS-1:0]   whole_ff, whole_in;
   logic [FRAC_BITS-1:0]  frac_ff, frac_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic                  past_point_ff, past_point_in;
   logic                  negative_ff, negative_in;
   logic                  at_start_ff, at_start_in;
   logic                  saturated_ff, saturated_in;

   // finished number snapshot
   logic          fin_valid_ff, fin_valid_in;
   adf_final_type fin_ff, fin_in;

   // result register
   logic        rsp_valid_ff, rsp_valid_in;
   adf_rsp_type rsp_ff, rsp_in;

   logic out_free, fin_free, in_go, in_free;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign fin_free  = !fin_valid_ff || out_free;
   assign in_go     = in_valid_ff && (!in_ff.last || fin_free);
   assign in_free   = !in_valid_ff || in_go;
   assign req_stall = !in_free;

   assign in_valid_in = in_free ? req_valid : in_valid_ff;

   // accumulator update
   logic [7:0]            ch;
   logic                  is_digit, minus_hit, point_hit;
   logic [3:0]            digit;
   logic [INT_BITS+3:0]   whole_ext, whole_sum;
   logic [FRAC_BITS+3:0]  frac_prod, frac_sum;
   logic [COUNT_BITS-1:0] count_next;
   logic [INT_BITS-1:0]   whole_upd;
   logic [FRAC_BITS-1:0]  frac_upd;
   logic [COUNT_BITS-1:0] count_upd;
   logic                  past_point_upd, negative_upd, saturated_upd;

   assign ch        = in_ff.character;
   assign is_digit  = (ch >= CHAR_ZERO) && (ch <= CHAR_NINE);
   assign minus_hit = at_start_ff && (ch == CHAR_MINUS);
   assign point_hit = !minus_hit && (ch == CHAR_POINT);
   assign digit     = 4'(ch - CHAR_ZERO);

   assign whole_ext  = {4'b0, whole_ff};
   assign whole_sum  = (whole_ext << 3) + (whole_ext << 1) + (INT_BITS + 4)'(digit);
   assign count_next = count_ff + COUNT_BITS'(1);
   assign frac_prod  = (FRAC_BITS + 4)'(digit) * (FRAC_BITS + 4)'(weight_table[count_next]);
   assign frac_sum   = {4'b0, frac_ff} + frac_prod;

   always_comb begin
      whole_upd      = whole_ff;
      frac_upd       = frac_ff;
      count_upd      = count_ff;
      past_point_upd = past_point_ff;
      negative_upd   = negative_ff;
      saturated_upd  = saturated_ff;
      if (minus_hit) begin
         negative_upd = 1'b1;
      end else if (point_hit) begin
         past_point_upd = 1'b1;
      end else if (is_digit) begin
         if (!past_point_ff) begin
            if (|whole_sum[INT_BITS+3:INT_BITS]) begin
               whole_upd     = '1;
               saturated_upd = 1'b1;
            end else begin
               whole_upd = whole_sum[INT_BITS-1:0];
            end
         end else if (count_ff < COUNT_BITS'(FRAC_DIGITS)) begin
            count_upd = count_next;
            frac_upd  = (|frac_sum[FRAC_BITS+3:FRAC_BITS]) ? '1 : frac_sum[FRAC_BITS-1:0];
         end
      end
   end

   always_comb begin
      whole_in      = whole_ff;
      frac_in       = frac_ff;
      count_in      = count_ff;
      past_point_in = past_point_ff;
      negative_in   = negative_ff;
      at_start_in   = at_start_ff;
      saturated_in  = saturated_ff;
      if (in_go) begin
         if (in_ff.last) begin
            whole_in      = '0;
            frac_in       = '0;
            count_in      = '0;
            past_point_in = 1'b0;
            negative_in   = 1'b0;
            at_start_in   = 1'b1;
            saturated_in  = 1'b0;
         end else begin
            whole_in      = whole_upd;
            frac_in       = frac_upd;
            count_in      = count_upd;
            past_point_in = past_point_upd;
            negative_in   = negative_upd;
            at_start_in   = 1'b0;
            saturated_in  = saturated_upd;
         end
      end
   end

   assign fin_valid_in = fin_free ? (in_go && in_ff.last) : fin_valid_ff;
   assign fin_in = '{whole: whole_upd, frac: frac_upd, negative: negative_upd,
                     saturated: saturated_upd};

   // output formatting
   logic [MAG_BITS+VALUE_BITS-1:0] mag_ext;
   logic [VALUE_BITS-1:0]          mag, lim, mag_out;
   logic                           clip;

   assign mag_ext = {{VALUE_BITS{1'b0}}, fin_ff.whole, fin_ff.frac};
   assign mag     = mag_ext[VALUE_BITS-1:0];
   assign lim     = fin_ff.negative ? LIM_NEG : LIM_POS;
   assign clip    = fin_ff.saturated || (mag > lim);
   assign mag_out = clip ? lim : mag;

   assign rsp_valid_in    = out_free ? fin_valid_ff : rsp_valid_ff;
   assign rsp_in.value    = $signed(fin_ff.negative ? (~mag_out + 64'd1) : mag_out);
   assign rsp_in.overflow = clip;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         fin_valid_ff  <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         whole_ff      <= '0;
         frac_ff       <= '0;
         count_ff      <= '0;
         past_point_ff <= 1'b0;
         negative_ff   <= 1'b0;
         at_start_ff   <= 1'b1;
         saturated_ff  <= 1'b0;
      end else begin
         in_valid_ff   <= in_valid_in;
         fin_valid_ff  <= fin_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         whole_ff      <= whole_in;
         frac_ff       <= frac_in;
         count_ff      <= count_in;
         past_point_ff <= past_point_in;
         negative_ff   <= negative_in;
         at_start_ff   <= at_start_in;
         saturated_ff  <= saturated_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_free && req_valid) begin
         in_ff <= req_payload;
      end
      if (fin_free && in_go && in_ff.last) begin
         fin_ff <= fin_in;
      end
      if (out_free && fin_valid_ff) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

`ifndef NO_ASSERTIONS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_BITS'(FRAC_DIGITS))
      else $error("fraction digit count beyond limit");

   a_count_needs_point: assert property (@(posedge clock) disable iff (reset)
      !past_point_ff |-> (count_ff == '0))
      else $error("fraction digits counted before point");

   a_restart_after_last: assert property (@(posedge clock) disable iff (reset)
      (in_go && in_ff.last) |=> (at_start_ff && !saturated_ff && whole_ff == '0))
      else $error("accumulators not cleared after last character");

   a_saturation_flags: assert property (@(posedge clock) disable iff (reset)
      (out_free && fin_valid_ff && fin_ff.saturated) |=> (rsp_valid_ff && rsp_ff.overflow))
      else $error("saturated integer part without overflow");
`endif

endmodule
